>>> sv/bks_pkg.sv
// ----------------------------------------------------------------------------
// bks_pkg: shared types and codes of the bounded key set
// Request modes, result status codes and the control word that the top level
// broadcasts along the row of key cells.
// ----------------------------------------------------------------------------
package bks_pkg;

    // Width of one key held in a cell.
    localparam int KEY_W = 32;

    // Request modes.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef logic [KEY_W-1:0] key_t;

    // Update command broadcast to every cell in the execute cycle.
    typedef struct packed {
        logic add_en;   // write the request key into the tail cell
        logic rem_en;   // cells from the matching one onwards take their neighbour's key
    } bks_ctrl_t;

endpackage

>>> sv/bks_cell.sv
// ----------------------------------------------------------------------------
// bks_cell: one slot of the key set
// Holds a single key, compares it with the request key, and on a removal
// takes the key of its upper neighbour so that the row stays packed.
// ----------------------------------------------------------------------------
module bks_cell
    import bks_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
)
(
    input  logic          clk,
    input  key_t          req_key,
    input  logic [CW-1:0] count,
    input  bks_ctrl_t     ctrl,
    input  key_t          neighbour_key,
    input  logic          seen_in,
    output logic          seen_out,
    output key_t          held_key
);

    key_t key_reg;
    key_t key_next;
    logic occupied;
    logic match;
    logic is_tail;

    // The cell is in use when its index lies below the entry count.
    assign occupied = (count > CW'(IDX));
    assign is_tail  = (count == CW'(IDX));
    assign match    = occupied && (key_reg == req_key);

    // The match flag ripples up the row; every cell above a match shifts down.
    assign seen_out = seen_in | match;
    assign held_key = key_reg;

    // Next key: append at the tail, or close the gap left by a removal.
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.add_en && is_tail)
        begin
            key_next = req_key;
        end
        else if (ctrl.rem_en && seen_out)
        begin
            key_next = neighbour_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

>>> sv/bounded_key_set.sv
// ----------------------------------------------------------------------------
// bounded_key_set: set of up to CAPACITY 32-bit keys
// Top level: request capture, the row of key cells, the entry count and the
// result register.
// ----------------------------------------------------------------------------
// Each request (add, remove, query or clear) is first captured; then every
// cell compares its key with the request at once and the row is updated. A
// new item is not taken while a request is in flight, and a stalled result
// holds the input side off. Keys are kept packed in cells 0 to count-1; a
// removal closes the gap by shifting the cells above the match down by one,
// so the order of the held keys may differ from a swap-with-last scheme, but
// every result is the same. entries_held shows the count in its low six bits.
module bounded_key_set
    import bks_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        member,
    output logic [5:0]  entries_held
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic          busy_reg;
    logic [1:0]    mode_reg;
    key_t          req_key_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          member_reg;
    logic [5:0]    held_reg;

    logic          accept;
    logic          hit;
    logic          full;
    bks_ctrl_t     ctrl;
    logic [CAPACITY:0] seen;
    key_t          cell_key [CAPACITY];

    // An item is taken only when no request is in flight and the result slot
    // is free or being emptied.
    assign in_stall = busy_reg | (out_valid_reg & out_stall);
    assign accept   = in_valid & ~in_stall;

    // Row of cells; the match flag ripples from cell 0 upwards.
    assign seen[0] = 1'b0;
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            key_t nb_key;
            if (i == CAPACITY - 1)
            begin : g_top
                assign nb_key = cell_key[i];
            end
            else
            begin : g_mid
                assign nb_key = cell_key[i+1];
            end

            bks_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk           (clk),
                .req_key       (req_key_reg),
                .count         (count_reg),
                .ctrl          (ctrl),
                .neighbour_key (nb_key),
                .seen_in       (seen[i]),
                .seen_out      (seen[i+1]),
                .held_key      (cell_key[i])
            );
        end
    endgenerate

    assign hit  = seen[CAPACITY];
    assign full = (count_reg >= CW'(CAPACITY));

    // Decode the request into a row command, the new count and the status.
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_OK;
        if (busy_reg)
        begin
            case (mode_reg)
                MODE_ADD:
                begin
                    if (hit)
                    begin
                        status_next = ST_PRESENT;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.add_en = 1'b1;
                        count_next  = count_reg + CW'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (hit)
                    begin
                        ctrl.rem_en = 1'b1;
                        count_next  = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                    end
                end
                MODE_QUERY:
                begin
                    status_next = hit ? ST_OK : ST_MISSING;
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
    end

    // Request capture and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= accept;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            req_key_reg <= key;
        end
    end

    // Result register: loaded at the end of the execute cycle, held while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            status_reg <= status_next;
            member_reg <= hit;
            held_reg   <= 6'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign member       = member_reg;
    assign entries_held = held_reg;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A request in flight always finds the result slot empty.
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !out_valid_reg)
        else $error("result slot occupied during execute");

    // Every executed request yields a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> out_valid_reg)
        else $error("executed request produced no result");

    // A full report only when the table really is full.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && status_next == ST_FULL) |-> (count_reg == CW'(CAPACITY)))
        else $error("full reported below capacity");

endmodule
